// File: design/sm4_dynamic_password_defines.svh
// Assertion macros shared by the SM4 dynamic password RTL.
// Depends on nothing; each user module provides i_clk and i_rst_n.
`ifndef SM4_DYNAMIC_PASSWORD_DEFINES_SVH
`define SM4_DYNAMIC_PASSWORD_DEFINES_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define SDP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define SDP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SDP_ASSERT_NOW(lbl, ante, cons, msg)
`define SDP_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

// File: design/sdp_pkg.sv
// Shared types, constants and SM4 helper functions for the dynamic password block.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package sdp_pkg;

    localparam int MIN_CHAL_DEF = 4;
    localparam int MAX_CHAL_DEF = 16;
    localparam int MAX_KEY_DEF  = 32;

    // configuration register indexes
    localparam logic [2:0] REG_KEY0   = 3'd0;
    localparam logic [2:0] REG_KEY1   = 3'd1;
    localparam logic [2:0] REG_KEY2   = 3'd2;
    localparam logic [2:0] REG_KEY3   = 3'd3;
    localparam logic [2:0] REG_KEYLEN = 3'd4;
    localparam logic [2:0] REG_TSTEP  = 3'd5;
    localparam logic [2:0] REG_DIGITS = 3'd6;

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_DIV, S_INIT, S_LOADK, S_RND, S_ADD, S_MODI, S_MOD, S_OUT
    } t_state;

    typedef struct packed {
        logic load;
        logic div_step;
        logic blk_init;
        logic blk_load;
        logic rnd_step;
        logic blk_add;
        logic mod_init;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic err;
        logic need_div;
        logic div_last;
        logic rnd_last;
        logic blk_last;
    } t_status;

    localparam logic [7:0] SBOX [256] = '{
        8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
        8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
        8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
        8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
        8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
        8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
        8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
        8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
        8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
        8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
        8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
        8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
        8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
        8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
        8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
        8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
    };

    localparam logic [31:0] FK [4] = '{32'ha3b1bac6, 32'h56aa3350, 32'h677d9197, 32'hb27022dc};

    function automatic logic [31:0] tau(input logic [31:0] x);
        tau = {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
    endfunction

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction

    // round constant: byte j = (4*rnd + j) * 7, low 8 bits
    function automatic logic [31:0] sm4_ck(input logic [4:0] rnd);
        logic [31:0] ck;
        logic [7:0]  base;
        ck   = '0;
        base = {1'b0, rnd, 2'b00};
        for (int j = 0; j < 4; j++) begin
            ck = {ck[23:0], 8'((base + 8'(j)) * 8'd7)};
        end
        sm4_ck = ck;
    endfunction

    // 10^digits, saturating at nine digits
    function automatic logic [29:0] pow10(input logic [3:0] d);
        case (d)
            4'd0:    pow10 = 30'd1;
            4'd1:    pow10 = 30'd10;
            4'd2:    pow10 = 30'd100;
            4'd3:    pow10 = 30'd1000;
            4'd4:    pow10 = 30'd10000;
            4'd5:    pow10 = 30'd100000;
            4'd6:    pow10 = 30'd1000000;
            4'd7:    pow10 = 30'd10000000;
            4'd8:    pow10 = 30'd100000000;
            default: pow10 = 30'd1000000000;
        endcase
    endfunction

endpackage
`default_nettype wire

// File: design/sm4_dynamic_password.sv
// Top level: APB register file, stream ports, output register, controller and datapath.
// Depends on sdp_pkg, sdp_ctrl and sdp_dpath.
//
//  port group | dir | data
//  s_axis_*   | in  | one password request per transfer
//  m_axis_*   | out | one password result per request
//  APB        | in  | key, key length, time step, digit count
//
// A rejected request goes from the check state straight to the output state.
// Otherwise the time division runs first (skipped when the time step is zero),
// then each SM4 block runs one round per cycle through the shared round unit,
// and one or two blocks run; the final modulo runs on the same divider. The
// block returns to idle after each request before it takes the next transfer.
// Reset is synchronous.
// A new request is taken while a finished result waits on m_axis; the block
// holds in its output state while the output register is full.
`timescale 1ns / 1ps
`default_nettype none
module sm4_dynamic_password
    import sdp_pkg::*;
#(
    parameter int MIN_CHALLENGE_BYTES = MIN_CHAL_DEF,
    parameter int MAX_CHALLENGE_BYTES = MAX_CHAL_DEF,
    parameter int MAX_KEY_BYTES       = MAX_KEY_DEF
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // time_value[63:0], counter_value[95:64], challenge_high[159:96],
    // challenge_low[223:160], challenge_length[228:224], zero fill
    input  wire logic [231:0] s_axis_tdata,
    // use_time[0], use_counter[1]
    input  wire logic [1:0]   s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // password[29:0], zero fill
    output logic [31:0]       m_axis_tdata,
    // param_error[0]
    output logic [0:0]        m_axis_tuser,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [5:0]   paddr,
    input  wire logic [63:0]  pwdata,
    output logic [63:0]       prdata,
    output logic              pready
);

    logic [63:0] r_key [4];
    logic [5:0]  r_key_len;
    logic [63:0] r_tstep;
    logic [3:0]  r_digits;
    logic [2:0]  reg_idx;
    logic        cfg_wr;

    assign pready  = 1'b1;
    assign reg_idx = paddr[5:3];
    assign cfg_wr  = psel && penable && pwrite;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) r_key[i] <= '0;
            r_key_len <= 6'd16;
            r_tstep   <= 64'd30;
            r_digits  <= 4'd6;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_KEY0:   r_key[0]  <= pwdata;
                REG_KEY1:   r_key[1]  <= pwdata;
                REG_KEY2:   r_key[2]  <= pwdata;
                REG_KEY3:   r_key[3]  <= pwdata;
                REG_KEYLEN: r_key_len <= pwdata[5:0];
                REG_TSTEP:  r_tstep   <= pwdata;
                REG_DIGITS: r_digits  <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // register readback
    always_comb begin
        case (reg_idx)
            REG_KEY0:   prdata = r_key[0];
            REG_KEY1:   prdata = r_key[1];
            REG_KEY2:   prdata = r_key[2];
            REG_KEY3:   prdata = r_key[3];
            REG_KEYLEN: prdata = {58'd0, r_key_len};
            REG_TSTEP:  prdata = r_tstep;
            REG_DIGITS: prdata = {60'd0, r_digits};
            default:    prdata = '0;
        endcase
    end

    t_cmd        cmd;
    t_status     status;
    logic        out_free;
    logic [29:0] password;
    logic        param_error;
    logic        r_m_tvalid;
    logic [29:0] r_m_pass;
    logic        r_m_err;

    assign out_free = !r_m_tvalid || m_axis_tready;

    sdp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_out_free (out_free),
        .i_status   (status),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    sdp_dpath #(
        .MIN_CHALLENGE_BYTES (MIN_CHALLENGE_BYTES),
        .MAX_CHALLENGE_BYTES (MAX_CHALLENGE_BYTES),
        .MAX_KEY_BYTES       (MAX_KEY_BYTES)
    ) u_dpath (
        .i_clk              (i_clk),
        .i_cmd              (cmd),
        .i_use_time         (s_axis_tuser[0]),
        .i_time_value       (s_axis_tdata[63:0]),
        .i_use_counter      (s_axis_tuser[1]),
        .i_counter_value    (s_axis_tdata[95:64]),
        .i_challenge        ({s_axis_tdata[159:96], s_axis_tdata[223:160]}),
        .i_challenge_length (s_axis_tdata[228:224]),
        .i_key              ({r_key[0], r_key[1], r_key[2], r_key[3]}),
        .i_key_length       (r_key_len),
        .i_time_step        (r_tstep),
        .i_digit_count      (r_digits),
        .o_status           (status),
        .o_password         (password),
        .o_param_error      (param_error)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (cmd.out_load) begin
            r_m_tvalid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.out_load) begin
            r_m_pass <= password;
            r_m_err  <= param_error;
        end
    end

    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = {2'b00, r_m_pass};
    assign m_axis_tuser  = r_m_err;

endmodule
`default_nettype wire

// File: design/sdp_ctrl.sv
// Sequencing state machine for the dynamic password block.
// Depends on sdp_pkg and sm4_dynamic_password_defines.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "sm4_dynamic_password_defines.svh"
module sdp_ctrl
    import sdp_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_out_free,
    input  wire t_status i_status,
    output logic         o_in_ready,
    output t_cmd         o_cmd
);

    t_state r_state, n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_CHECK;
            S_CHECK: begin
                if (i_status.err)           n_state = S_OUT;
                else if (i_status.need_div) n_state = S_DIV;
                else                        n_state = S_INIT;
            end
            S_DIV:   if (i_status.div_last) n_state = S_INIT;
            S_INIT:  n_state = S_LOADK;
            S_LOADK: n_state = S_RND;
            S_RND:   if (i_status.rnd_last) n_state = S_ADD;
            S_ADD:   n_state = i_status.blk_last ? S_MODI : S_LOADK;
            S_MODI:  n_state = S_MOD;
            S_MOD:   if (i_status.div_last) n_state = S_OUT;
            S_OUT:   if (i_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_DIV, S_MOD: o_cmd.div_step = 1'b1;
            S_INIT:  o_cmd.blk_init = 1'b1;
            S_LOADK: o_cmd.blk_load = 1'b1;
            S_RND:   o_cmd.rnd_step = 1'b1;
            S_ADD:   o_cmd.blk_add  = 1'b1;
            S_MODI:  o_cmd.mod_init = 1'b1;
            S_OUT:   o_cmd.out_load = i_out_free;
            default: o_cmd = '0;
        endcase
    end

    `SDP_ASSERT_NEXT(a_load_check, o_cmd.load, r_state == S_CHECK, "load not followed by check")
    `SDP_ASSERT_NOW(a_out_slot, o_cmd.out_load, i_out_free, "result loaded into busy slot")
    `SDP_ASSERT_NEXT(a_err_out, (r_state == S_CHECK) && i_status.err, r_state == S_OUT,
        "rejected request did not go to output")

endmodule
`default_nettype wire

// File: design/sdp_dpath.sv
// Datapath: request capture, shared restoring divider, SM4 round unit, block adders.
// Depends on sdp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sdp_dpath
    import sdp_pkg::*;
#(
    parameter int MIN_CHALLENGE_BYTES = MIN_CHAL_DEF,
    parameter int MAX_CHALLENGE_BYTES = MAX_CHAL_DEF,
    parameter int MAX_KEY_BYTES       = MAX_KEY_DEF
) (
    input  wire logic          i_clk,
    input  wire t_cmd          i_cmd,
    input  wire logic          i_use_time,
    input  wire logic [63:0]   i_time_value,
    input  wire logic          i_use_counter,
    input  wire logic [31:0]   i_counter_value,
    input  wire logic [127:0]  i_challenge,
    input  wire logic [4:0]    i_challenge_length,
    input  wire logic [255:0]  i_key,
    input  wire logic [5:0]    i_key_length,
    input  wire logic [63:0]   i_time_step,
    input  wire logic [3:0]    i_digit_count,
    output t_status            o_status,
    output logic [29:0]        o_password,
    output logic               o_param_error
);

    logic         r_use_time, r_use_cnt, r_err, r_two_k, r_two_i, r_blk;
    logic [31:0]  r_cnt_val;
    logic [127:0] r_chal, r_key0, r_key1, r_id0, r_id1, r_o;
    logic [4:0]   r_qlen;
    logic [63:0]  r_quo, r_rem, r_dvs;
    logic [5:0]   r_step;
    logic [31:0]  r_k [4];
    logic [31:0]  r_x [4];

    // request check
    logic [4:0] qsat;
    logic       err_in;
    always_comb begin
        qsat   = (i_challenge_length > 5'(MAX_CHALLENGE_BYTES)) ?
                 5'(MAX_CHALLENGE_BYTES) : i_challenge_length;
        err_in = (!i_use_time && !i_use_counter && qsat == 5'd0) ||
                 (qsat != 5'd0 && qsat < 5'(MIN_CHALLENGE_BYTES));
    end

    // initial key and ID blocks
    logic [127:0] chal_mask;
    logic [255:0] id_acc, key_mask, key_in;
    logic [5:0]   idlen, klen_sat;
    always_comb begin
        chal_mask = ~({128{1'b1}} >> {r_qlen, 3'b000});
        id_acc    = {r_chal & chal_mask, 128'd0};
        if (r_use_cnt) id_acc = {r_cnt_val, id_acc[255:32]};
        if (r_use_time) id_acc = {r_quo, id_acc[255:64]};
        idlen     = {2'b00, r_use_time, 3'b000} + {3'b000, r_use_cnt, 2'b00} + {1'b0, r_qlen};
        klen_sat  = (i_key_length > 6'(MAX_KEY_BYTES)) ? 6'(MAX_KEY_BYTES) : i_key_length;
        key_mask  = ~({256{1'b1}} >> {klen_sat, 3'b000});
        key_in    = i_key & key_mask;
    end

    // divider step: one quotient bit per cycle
    logic [64:0] trial;
    logic        take;
    always_comb begin
        trial = {r_rem, r_quo[63]};
        take  = trial >= {1'b0, r_dvs};
    end

    // SM4 round: key schedule then data round
    logic [31:0] b_k, rk, b_x, t_x;
    always_comb begin
        b_k = tau(r_k[1] ^ r_k[2] ^ r_k[3] ^ sm4_ck(r_step[4:0]));
        rk  = r_k[0] ^ b_k ^ rotl(b_k, 13) ^ rotl(b_k, 23);
        b_x = tau(r_x[1] ^ r_x[2] ^ r_x[3] ^ rk);
        t_x = r_x[0] ^ b_x ^ rotl(b_x, 2) ^ rotl(b_x, 10) ^ rotl(b_x, 18) ^ rotl(b_x, 24);
    end

    logic [127:0] o_blk;
    logic [31:0]  word_sum;
    always_comb begin
        o_blk    = {r_x[3], r_x[2], r_x[1], r_x[0]};
        word_sum = r_o[127:96] + r_o[95:64] + r_o[63:32] + r_o[31:0];
    end

    // request capture and divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_use_time <= i_use_time;
            r_use_cnt  <= i_use_counter;
            r_cnt_val  <= i_counter_value;
            r_chal     <= i_challenge;
            r_qlen     <= qsat;
            r_err      <= err_in;
            r_quo      <= i_time_value;
            r_rem      <= '0;
            r_dvs      <= i_time_step;
        end else if (i_cmd.mod_init) begin
            r_quo <= {32'd0, word_sum};
            r_rem <= '0;
            r_dvs <= {34'd0, pow10(i_digit_count)};
        end else if (i_cmd.div_step) begin
            r_rem <= take ? 64'(trial - {1'b0, r_dvs}) : trial[63:0];
            r_quo <= {r_quo[62:0], take};
        end
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (i_cmd.load || i_cmd.blk_load || i_cmd.mod_init) begin
            r_step <= '0;
        end else if (i_cmd.div_step || i_cmd.rnd_step) begin
            r_step <= r_step + 6'd1;
        end
    end

    // key and ID blocks
    always_ff @(posedge i_clk) begin
        if (i_cmd.blk_init) begin
            r_key0  <= key_in[255:128];
            r_key1  <= key_in[127:0];
            r_id0   <= id_acc[255:128];
            r_id1   <= id_acc[127:0];
            r_two_k <= klen_sat > 6'd16;
            r_two_i <= idlen > 6'd16;
            r_blk   <= 1'b0;
        end else if (i_cmd.blk_add) begin
            r_key0 <= o_blk + (r_two_k ? r_key1 : r_key0);
            r_id0  <= o_blk + (r_two_i ? r_id1 : r_id0);
            r_o    <= o_blk;
            r_blk  <= 1'b1;
        end
    end

    // round registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.blk_load) begin
            for (int i = 0; i < 4; i++) begin
                r_k[i] <= r_key0[127 - 32 * i -: 32] ^ FK[i];
                r_x[i] <= r_id0[127 - 32 * i -: 32];
            end
        end else if (i_cmd.rnd_step) begin
            r_k[0] <= r_k[1]; r_k[1] <= r_k[2]; r_k[2] <= r_k[3]; r_k[3] <= rk;
            r_x[0] <= r_x[1]; r_x[1] <= r_x[2]; r_x[2] <= r_x[3]; r_x[3] <= t_x;
        end
    end

    always_comb begin
        o_status.err      = r_err;
        o_status.need_div = i_time_step != 64'd0;
        o_status.div_last = r_step == 6'd63;
        o_status.rnd_last = r_step[4:0] == 5'd31;
        o_status.blk_last = r_blk || !(r_two_k || r_two_i);
        o_password        = r_err ? 30'd0 : r_rem[29:0];
        o_param_error     = r_err;
    end

endmodule
`default_nettype wire
